FILE: rtl/core/tkst_pkg.sv
// Shared constants and types for the streaming top-k tracker.
package tkst_pkg;

   // Fixed field widths of the request, response and csr beats
   localparam int DATA_W  = 32;
   localparam int COUNT_W = 5;
   localparam int POS_W   = 4;

   // Defaults for the top-level parameters
   localparam int DEPTH_DEF       = 16;
   localparam int VALUE_WIDTH_DEF = 32;

   // Request commands
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   // Per-cycle shift command broadcast to every cell of the row
   typedef struct packed {
      logic place;     // open a slot above the new value and write it
      logic replace;   // drop the minimum, slide down, write the new value
   } tkst_shift_type;

   // Result slot control from the query sequencer
   typedef struct packed {
      logic             fire;
      logic [POS_W-1:0] position;
      logic             last;
      logic             item_valid;
   } tkst_emit_type;

endpackage

FILE: rtl/core/tkst_if.sv
// Request and response channel interfaces of the top-k tracker.
interface tkst_req_if import tkst_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     cmd;
   logic signed [DATA_W-1:0] value;
   logic [COUNT_W-1:0]       count;
   logic                     ascending;

   modport source (output valid, cmd, value, count, ascending, input ready);
   modport sink   (input valid, cmd, value, count, ascending, output ready);
endinterface

interface tkst_rsp_if import tkst_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] result_value;
   logic [POS_W-1:0]         position;
   logic                     last;
   logic                     item_valid;
   logic [COUNT_W-1:0]       stored_count;
   logic                     overflowed;

   modport source (output valid, result_value, position, last, item_valid, stored_count,
                   overflowed, input ready);
   modport sink   (input valid, result_value, position, last, item_valid, stored_count,
                   overflowed, output ready);
endinterface

FILE: rtl/core/tkst_cell.sv
// One entry of the sorted row: holds a value and trades with its neighbors.
module tkst_cell import tkst_pkg::*; #(
   parameter int VW    = VALUE_WIDTH_DEF,
   parameter int CNT_W = 5,
   parameter int INDEX = 0
) (
   input  logic                 clock,
   input  tkst_shift_type       ctrl,
   input  logic [CNT_W-1:0]     held,
   input  logic signed [VW-1:0] ins_value,
   input  logic signed [VW-1:0] left_value,
   input  logic                 left_gt,
   input  logic signed [VW-1:0] right_value,
   input  logic                 right_lt,
   output logic signed [VW-1:0] cell_value,
   output logic                 gt,
   output logic                 lt
);

   logic signed [VW-1:0] value_ff;
   logic signed [VW-1:0] value_in;
   logic                 in_range;
   logic                 is_tail;

   assign in_range   = CNT_W'(INDEX) < held;
   assign is_tail    = CNT_W'(INDEX) == held;
   assign gt         = in_range && (value_ff > ins_value);
   assign lt         = in_range && (value_ff < ins_value);
   assign cell_value = value_ff;

   // Pick the next entry: shift up on place, shift down on replace
   always_comb begin
      value_in = value_ff;
      if (ctrl.place && (in_range || is_tail)) begin
         if (left_gt) begin
            value_in = left_value;
         end else if (gt || is_tail) begin
            value_in = ins_value;
         end
      end else if (ctrl.replace && in_range) begin
         if (right_lt) begin
            value_in = right_value;
         end else if (lt) begin
            value_in = ins_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

FILE: rtl/core/tkst_query_seq.sv
// Query sequencer: walks the sorted row and paces one result per free slot.
module tkst_query_seq import tkst_pkg::*; #(
   parameter int CNT_W = 5,
   parameter int IDX_W = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [COUNT_W-1:0] count,
   input  logic               ascending,
   input  logic [CNT_W-1:0]   held,
   input  logic               slot_free,
   output logic               busy,
   output logic [IDX_W-1:0]   rd_idx,
   output tkst_emit_type      emit
);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             asc_ff, asc_in;
   logic             empty_ff, empty_in;
   logic [CNT_W-1:0] n_start;
   logic             is_last;

   // Clamp the wanted count to what is held; zero means all
   assign n_start = (count == '0 || 32'(count) > 32'(held)) ? held : CNT_W'(count);
   assign is_last = empty_ff || (CNT_W'(k_ff + 1'b1) == n_ff);

   assign busy            = busy_ff;
   assign rd_idx          = idx_ff;
   assign emit.fire       = busy_ff && slot_free;
   assign emit.position   = POS_W'(k_ff);
   assign emit.last       = is_last;
   assign emit.item_valid = !empty_ff;

   always_comb begin
      busy_in  = busy_ff;
      k_in     = k_ff;
      n_in     = n_ff;
      idx_in   = idx_ff;
      asc_in   = asc_ff;
      empty_in = empty_ff;
      if (start) begin
         // Load the run: ascending starts at the smallest wanted entry
         busy_in  = 1'b1;
         k_in     = '0;
         n_in     = n_start;
         asc_in   = ascending;
         empty_in = (held == '0);
         idx_in   = ascending ? IDX_W'(CNT_W'(held - n_start)) : IDX_W'(CNT_W'(held - 1'b1));
      end else if (busy_ff && slot_free) begin
         // Advance one beat
         k_in   = CNT_W'(k_ff + 1'b1);
         idx_in = asc_ff ? IDX_W'(idx_ff + 1'b1) : IDX_W'(idx_ff - 1'b1);
         if (is_last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      k_ff     <= k_in;
      n_ff     <= n_in;
      idx_ff   <= idx_in;
      asc_ff   <= asc_in;
      empty_ff <= empty_in;
   end

endmodule

FILE: rtl/core/top_k_stream_tracker.sv
// An accepted insert shows in the row in the next cycle; one insert is taken every cycle
// while no query run is in flight. A query of n results first registers the run in the
// sequencer, then loads each result into the response register, one result per cycle while
// the consumer takes them; the next request waits until the last result has been loaded.
// The insert rate is set by the row of compare/shift cells, the query rate by the response slot.
// Reset (synchronous) empties the store, clears the overflow flag and capacity.
module top_k_stream_tracker import tkst_pkg::*; #(
   parameter int DEPTH       = DEPTH_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   tkst_req_if.sink           req_bus,
   tkst_rsp_if.source         rsp_bus,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [COUNT_W-1:0]        capacity_ff;
   logic [CNT_W-1:0]          held_ff, held_in;
   logic                      overflow_ff, overflow_in;
   logic signed [VALUE_WIDTH-1:0] ins_value;
   logic signed [VALUE_WIDTH-1:0] cell_value [DEPTH];
   logic                      cell_gt [DEPTH];
   logic                      cell_lt [DEPTH];
   tkst_shift_type            shift;
   logic                      ins_accept;
   logic                      qry_accept;
   logic                      unbounded;
   logic                      full;
   logic                      busy;
   logic                      slot_free;
   logic [IDX_W-1:0]          rd_idx;
   tkst_emit_type             emit;

   logic                      rsp_valid_ff;
   logic signed [DATA_W-1:0]  rsp_value_ff;
   logic [POS_W-1:0]          rsp_pos_ff;
   logic                      rsp_last_ff;
   logic                      rsp_item_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;
   logic                      rsp_ovf_ff;

   // Request handshake: hold off while a query run is being emitted
   assign req_bus.ready = !busy;
   assign ins_accept    = req_bus.valid && !busy && (req_bus.cmd == CMD_INSERT);
   assign qry_accept    = req_bus.valid && !busy && (req_bus.cmd == CMD_QUERY);
   assign ins_value     = VALUE_WIDTH'(req_bus.value);

   // Capacity decode: zero or above depth means keep up to depth
   assign unbounded = (capacity_ff == '0) || (32'(capacity_ff) > DEPTH);
   assign full      = unbounded ? (32'(held_ff) >= DEPTH) : (32'(held_ff) >= 32'(capacity_ff));

   assign shift.place   = ins_accept && !full;
   assign shift.replace = ins_accept && full && (held_ff != '0) && (ins_value > cell_value[0]);

   always_comb begin
      held_in     = shift.place ? CNT_W'(held_ff + 1'b1) : held_ff;
      overflow_in = overflow_ff || (ins_accept && full && unbounded);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= '0;
         held_ff     <= '0;
         overflow_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         held_ff     <= held_in;
         overflow_ff <= overflow_in;
      end
   end

   // Sorted row of cells, smallest at index zero
   for (genvar j = 0; j < DEPTH; j++) begin : g_cell
      logic signed [VALUE_WIDTH-1:0] left_value;
      logic signed [VALUE_WIDTH-1:0] right_value;
      logic                          left_gt;
      logic                          right_lt;

      if (j == 0) begin : g_first
         assign left_value = cell_value[j];
         assign left_gt    = 1'b0;
      end else begin : g_mid_l
         assign left_value = cell_value[j-1];
         assign left_gt    = cell_gt[j-1];
      end
      if (j == DEPTH - 1) begin : g_last
         assign right_value = cell_value[j];
         assign right_lt    = 1'b0;
      end else begin : g_mid_r
         assign right_value = cell_value[j+1];
         assign right_lt    = cell_lt[j+1];
      end

      tkst_cell #(
         .VW    (VALUE_WIDTH),
         .CNT_W (CNT_W),
         .INDEX (j)
      ) u_cell (
         .clock       (clock),
         .ctrl        (shift),
         .held        (held_ff),
         .ins_value   (ins_value),
         .left_value  (left_value),
         .left_gt     (left_gt),
         .right_value (right_value),
         .right_lt    (right_lt),
         .cell_value  (cell_value[j]),
         .gt          (cell_gt[j]),
         .lt          (cell_lt[j])
      );
   end

   assign slot_free = !rsp_valid_ff || rsp_bus.ready;

   tkst_query_seq #(
      .CNT_W (CNT_W),
      .IDX_W (IDX_W)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (qry_accept),
      .count     (req_bus.count),
      .ascending (req_bus.ascending),
      .held      (held_ff),
      .slot_free (slot_free),
      .busy      (busy),
      .rd_idx    (rd_idx),
      .emit      (emit)
   );

   // Response register: load on a sequencer beat, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit.fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit.fire) begin
         rsp_value_ff <= emit.item_valid ? DATA_W'(cell_value[rd_idx]) : '0;
         rsp_pos_ff   <= emit.position;
         rsp_last_ff  <= emit.last;
         rsp_item_ff  <= emit.item_valid;
         rsp_count_ff <= COUNT_W'(held_ff);
         rsp_ovf_ff   <= overflow_ff;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.result_value = rsp_value_ff;
   assign rsp_bus.position     = rsp_pos_ff;
   assign rsp_bus.last         = rsp_last_ff;
   assign rsp_bus.item_valid   = rsp_item_ff;
   assign rsp_bus.stored_count = rsp_count_ff;
   assign rsp_bus.overflowed   = rsp_ovf_ff;

endmodule

FILE: rtl/core/tkst_checker.sv
// Port-level checks for the top-k tracker, bound to the top level.
module tkst_checker import tkst_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [DATA_W-1:0] rsp_value,
   input logic [POS_W-1:0]         rsp_position,
   input logic                     rsp_last,
   input logic                     rsp_item_valid,
   input logic [COUNT_W-1:0]       rsp_stored_count
);

   // Hold a stalled response beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_position)
                                 && $stable(rsp_last))
      else $error("response beat changed while stalled");

   // A run in flight blocks new requests
   a_run_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request taken in the middle of a query run");

   // Empty-store result is a single beat at position zero
   a_empty_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item_valid |-> rsp_last && (rsp_position == '0)
                                       && (rsp_stored_count == '0))
      else $error("malformed empty-store result");

   // Positions advance by one within a run
   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
         !rsp_valid || (rsp_position == POS_W'($past(rsp_position) + 1'b1)))
      else $error("position did not advance by one");

endmodule

bind top_k_stream_tracker tkst_checker u_tkst_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_value        (rsp_bus.result_value),
   .rsp_position     (rsp_bus.position),
   .rsp_last         (rsp_bus.last),
   .rsp_item_valid   (rsp_bus.item_valid),
   .rsp_stored_count (rsp_bus.stored_count)
);
